FILE: design/aik_pkg.sv
// Shared constants for the arm inverse kinematics pipeline.
`default_nettype none

package aik_pkg;

    // Angles are signed, one LSB is 1/65536 rad.
    localparam int ANG_W     = 19;
    localparam int CORD_IN_W = 32;

    localparam int PI_Q      = 205887;
    localparam int PI_HALF_Q = 102944;

    localparam int ATAN_LEN = 24;
    localparam logic [16:0] ATAN_TAB [ATAN_LEN] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
        17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
    };

endpackage

`default_nettype wire

FILE: design/aik_cordic.sv
// Pipelined vectoring CORDIC that returns atan2(a, b) in fixed point.
`default_nettype none

module aik_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [aik_pkg::CORD_IN_W-1:0]   a_in,
    input  logic signed [aik_pkg::CORD_IN_W-1:0]   b_in,
    output logic signed [aik_pkg::ANG_W-1:0]       ang_out
);

    localparam int EXT_W = aik_pkg::CORD_IN_W + 1;
    localparam int FRAC  = 20;
    localparam int W     = EXT_W + FRAC + 3;
    localparam int AW    = aik_pkg::ANG_W;
    localparam logic signed [AW-1:0] PH = AW'(aik_pkg::PI_HALF_Q);

    logic signed [EXT_W-1:0] a_ext, b_ext, x_pre, y_pre;
    logic signed [AW-1:0]    ang_pre;
    logic                    zero_pre;

    logic signed [W-1:0]  x_reg   [STAGES+1];
    logic signed [W-1:0]  y_reg   [STAGES+1];
    logic signed [AW-1:0] ang_reg [STAGES+1];
    logic                 zero_reg [STAGES+1];

    assign a_ext    = {a_in[aik_pkg::CORD_IN_W-1], a_in};
    assign b_ext    = {b_in[aik_pkg::CORD_IN_W-1], b_in};
    assign zero_pre = (a_in == '0) && (b_in == '0);

    // A vector in the left half plane is first turned by a quarter turn.
    always_comb begin
        if (b_ext[EXT_W-1]) begin
            if (!a_ext[EXT_W-1]) begin
                x_pre   = a_ext;
                y_pre   = -b_ext;
                ang_pre = PH;
            end else begin
                x_pre   = -a_ext;
                y_pre   = b_ext;
                ang_pre = -PH;
            end
        end else begin
            x_pre   = b_ext;
            y_pre   = a_ext;
            ang_pre = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= {{(W-EXT_W-FRAC){x_pre[EXT_W-1]}}, x_pre, {FRAC{1'b0}}};
            y_reg[0]    <= {{(W-EXT_W-FRAC){y_pre[EXT_W-1]}}, y_pre, {FRAC{1'b0}}};
            ang_reg[0]  <= ang_pre;
            zero_reg[0] <= zero_pre;
        end
    end

    for (genvar i = 1; i <= STAGES; i++) begin : gen_stage
        localparam logic signed [AW-1:0] STEP = AW'(aik_pkg::ATAN_TAB[i-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i-1][W-1]) begin
                    x_reg[i]   <= x_reg[i-1] + (y_reg[i-1] >>> (i-1));
                    y_reg[i]   <= y_reg[i-1] - (x_reg[i-1] >>> (i-1));
                    ang_reg[i] <= ang_reg[i-1] + STEP;
                end else begin
                    x_reg[i]   <= x_reg[i-1] - (y_reg[i-1] >>> (i-1));
                    y_reg[i]   <= y_reg[i-1] + (x_reg[i-1] >>> (i-1));
                    ang_reg[i] <= ang_reg[i-1] - STEP;
                end
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // The zero vector has angle zero by definition.
    assign ang_out = zero_reg[STAGES] ? '0 : ang_reg[STAGES];

endmodule

`default_nettype wire

FILE: design/arm_ik_servo_pulses.sv
// Top level: target point to three servo pulse widths through a deep pipeline.
//
// Usage: a target (x, y, z) enters on the s_ channel (valid/ready) and one
// result item leaves on the m_ channel with the yaw, lift and bend pulse
// widths in microseconds and the unreachable flag.
// The pipeline runs squares and products, a bit-pair square root, one
// quarter-turn stage plus CORDIC_STAGES CORDIC iterations, and pulse scaling.
// Throughput is one item per cycle while the receiver does not hold the output;
// every stage is a register and four CORDIC pipelines and three square root
// pipelines run side by side.
// When the receiver holds m_ready low while a result waits, the whole pipeline
// freezes and s_ready falls; nothing is dropped or repeated. Empty stages move
// on whenever the output register is empty or being taken.
// Reset (synchronous, active low) empties the pipeline and loads the link
// lengths and servo centers with their defaults. Configuration must be written
// through cfg_wr_en / cfg_index / cfg_wr_data only while the pipeline is empty,
// which the block itself does not enforce; indexes above four are ignored.
`default_nettype none

module arm_ik_servo_pulses #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [14:0] s_target_x,
    input  logic signed [14:0] s_target_y,
    input  logic signed [14:0] s_target_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [11:0]        m_yaw_pulse,
    output logic [11:0]        m_lift_pulse,
    output logic [11:0]        m_bend_pulse,
    output logic               m_unreachable,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [13:0]        cfg_wr_data
);

    localparam logic [2:0] REG_UPPER = 3'd0;
    localparam logic [2:0] REG_LOWER = 3'd1;
    localparam logic [2:0] REG_YAW_C = 3'd2;
    localparam logic [2:0] REG_LIFT_C = 3'd3;
    localparam logic [2:0] REG_BEND_C = 3'd4;

    localparam int SQ_STEPS  = 31;
    localparam int SQ_IN_W   = 62;
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_REM_W  = 35;
    localparam int LAT       = 5 + SQ_STEPS + 1 + CORDIC_STAGES + 4;

    localparam int AW     = aik_pkg::ANG_W;
    localparam int CW     = aik_pkg::CORD_IN_W;
    localparam int SUM_W  = 22;
    localparam int T_W    = 21;
    localparam int K_W    = 26;
    localparam int PROD_W = T_W + K_W;
    localparam int RECIP_SHIFT = 32;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int PI_W   = 18;
    localparam int REM_W  = 19;
    localparam int V_W    = 17;

    localparam logic [63:0] RECIP_K = (64'd2000 << RECIP_SHIFT) / 64'(aik_pkg::PI_Q);
    localparam logic [PI_W-1:0] PI_U = PI_W'(aik_pkg::PI_Q);
    localparam logic signed [SUM_W-1:0] PH_S = SUM_W'(aik_pkg::PI_HALF_Q);
    localparam logic signed [SUM_W-1:0] PI_PH_S = SUM_W'(aik_pkg::PI_Q + aik_pkg::PI_HALF_Q);
    localparam logic [10:0] PULSE_SPAN = 11'd2000;
    localparam logic signed [V_W-1:0] PULSE_OFS = 17'sd1000;
    localparam logic signed [V_W-1:0] PULSE_MAX = 17'sd4095;

    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [14:0] z;
        logic signed [31:0] num_l;
        logic signed [31:0] num_b;
        logic               flag;
    } side_t;

    // Configuration registers.
    logic [13:0] upper_len_reg, lower_len_reg;
    logic [11:0] yaw_c_reg, lift_c_reg, bend_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= 14'd4096;
            lower_len_reg <= 14'd9216;
            yaw_c_reg     <= 12'd1532;
            lift_c_reg    <= 12'd1535;
            bend_c_reg    <= 12'd1525;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UPPER:  upper_len_reg <= cfg_wr_data;
                REG_LOWER:  lower_len_reg <= cfg_wr_data;
                REG_YAW_C:  yaw_c_reg     <= cfg_wr_data[11:0];
                REG_LIFT_C: lift_c_reg    <= cfg_wr_data[11:0];
                REG_BEND_C: bend_c_reg    <= cfg_wr_data[11:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance and valid chain.
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 1: squares of the coordinates and of the link lengths.
    logic signed [29:0] xx_full, yy_full, zz_full;
    logic        [27:0] uu_full, ll_full;
    logic signed [14:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic        [28:0] s1_xx_reg, s1_yy_reg, s1_zz_reg;
    logic        [27:0] s1_uu_reg, s1_ll_reg;

    assign xx_full = s_target_x * s_target_x;
    assign yy_full = s_target_y * s_target_y;
    assign zz_full = s_target_z * s_target_z;
    assign uu_full = upper_len_reg * upper_len_reg;
    assign ll_full = lower_len_reg * lower_len_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_x_reg  <= s_target_x;
            s1_y_reg  <= s_target_y;
            s1_z_reg  <= s_target_z;
            s1_xx_reg <= xx_full[28:0];
            s1_yy_reg <= yy_full[28:0];
            s1_zz_reg <= zz_full[28:0];
            s1_uu_reg <= uu_full;
            s1_ll_reg <= ll_full;
        end
    end

    // Stage 2: reach and radius squared, link sum and difference, bend denominator product.
    logic signed [14:0] s2_x_reg, s2_y_reg, s2_z_reg;
    logic        [29:0] s2_reach2_reg, s2_rad2_reg;
    logic signed [28:0] s2_uml_reg;
    logic        [28:0] s2_upl_reg;
    logic        [27:0] s2_uu_reg;
    logic        [55:0] s2_dbp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_x_reg      <= s1_x_reg;
            s2_y_reg      <= s1_y_reg;
            s2_z_reg      <= s1_z_reg;
            s2_reach2_reg <= {1'b0, s1_xx_reg} + {1'b0, s1_zz_reg};
            s2_rad2_reg   <= {1'b0, s1_xx_reg} + {1'b0, s1_zz_reg} + {1'b0, s1_yy_reg};
            s2_uml_reg    <= $signed({1'b0, s1_uu_reg}) - $signed({1'b0, s1_ll_reg});
            s2_upl_reg    <= {1'b0, s1_uu_reg} + {1'b0, s1_ll_reg};
            s2_uu_reg     <= s1_uu_reg;
            s2_dbp_reg    <= s1_uu_reg * s1_ll_reg;
        end
    end

    // Stage 3: cosine numerators and the lift denominator product.
    logic signed [14:0] s3_x_reg, s3_y_reg, s3_z_reg;
    logic        [29:0] s3_reach2_reg;
    logic signed [31:0] s3_numl_reg, s3_numb_reg;
    logic        [57:0] s3_dlp_reg;
    logic        [55:0] s3_dbp_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_x_reg      <= s2_x_reg;
            s3_y_reg      <= s2_y_reg;
            s3_z_reg      <= s2_z_reg;
            s3_reach2_reg <= s2_reach2_reg;
            s3_numl_reg   <= {{3{s2_uml_reg[28]}}, s2_uml_reg} + $signed({2'b00, s2_rad2_reg});
            s3_numb_reg   <= $signed({3'b000, s2_upl_reg}) - $signed({2'b00, s2_rad2_reg});
            s3_dlp_reg    <= s2_uu_reg * s2_rad2_reg;
            s3_dbp_reg    <= s2_dbp_reg;
        end
    end

    // Stage 4: squares of the numerators.
    logic signed [63:0] sql_full, sqb_full;
    logic signed [14:0] s4_x_reg, s4_y_reg, s4_z_reg;
    logic        [29:0] s4_reach2_reg;
    logic signed [31:0] s4_numl_reg, s4_numb_reg;
    logic        [61:0] s4_sql_reg, s4_sqb_reg;
    logic        [59:0] s4_dl_reg;
    logic        [57:0] s4_db_reg;

    assign sql_full = s3_numl_reg * s3_numl_reg;
    assign sqb_full = s3_numb_reg * s3_numb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_x_reg      <= s3_x_reg;
            s4_y_reg      <= s3_y_reg;
            s4_z_reg      <= s3_z_reg;
            s4_reach2_reg <= s3_reach2_reg;
            s4_numl_reg   <= s3_numl_reg;
            s4_numb_reg   <= s3_numb_reg;
            s4_sql_reg    <= sql_full[61:0];
            s4_sqb_reg    <= sqb_full[61:0];
            s4_dl_reg     <= {s3_dlp_reg, 2'b00};
            s4_db_reg     <= {s3_dbp_reg, 2'b00};
        end
    end

    // Stage 5: range check of the cosine arguments and square root operands.
    logic [SQ_IN_W-1:0] dl_ext, db_ext, diff_l, diff_b;
    logic               over_l, over_b;
    logic [SQ_IN_W-1:0] s5_sqin_reg [3];
    side_t              s5_side_reg;

    assign dl_ext = {2'b00, s4_dl_reg};
    assign db_ext = {4'b0000, s4_db_reg};
    assign diff_l = dl_ext - s4_sql_reg;
    assign diff_b = db_ext - s4_sqb_reg;
    assign over_l = (s4_dl_reg == '0) || (s4_sql_reg > dl_ext);
    assign over_b = (s4_db_reg == '0) || (s4_sqb_reg > db_ext);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_sqin_reg[0]    <= {12'd0, s4_reach2_reg, 20'd0};
            s5_sqin_reg[1]    <= over_l ? '0 : diff_l;
            s5_sqin_reg[2]    <= over_b ? '0 : diff_b;
            s5_side_reg.x     <= s4_x_reg;
            s5_side_reg.y     <= s4_y_reg;
            s5_side_reg.z     <= s4_z_reg;
            s5_side_reg.num_l <= s4_numl_reg;
            s5_side_reg.num_b <= s4_numb_reg;
            s5_side_reg.flag  <= over_l || over_b;
        end
    end

    // Three floor square roots, one result bit per stage.
    logic [SQ_IN_W-1:0]   sq_val_reg  [3][SQ_STEPS];
    logic [SQ_REM_W-1:0]  sq_rem_reg  [3][SQ_STEPS];
    logic [SQ_ROOT_W-1:0] sq_root_reg [3][SQ_STEPS];
    side_t                sq_side_reg [SQ_STEPS];

    for (genvar k = 0; k < 3; k++) begin : gen_sq_lane
        for (genvar j = 0; j < SQ_STEPS; j++) begin : gen_sq_step
            logic [SQ_IN_W-1:0]   val_in;
            logic [SQ_REM_W-1:0]  rem_in, cur, sub;
            logic [SQ_ROOT_W-1:0] root_in;
            logic                 take;

            if (j == 0) begin : gen_first
                assign val_in  = s5_sqin_reg[k];
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : gen_next
                assign val_in  = sq_val_reg[k][j-1];
                assign rem_in  = sq_rem_reg[k][j-1];
                assign root_in = sq_root_reg[k][j-1];
            end

            assign cur  = {rem_in[SQ_REM_W-3:0], val_in[SQ_IN_W-1 -: 2]};
            assign sub  = {{(SQ_REM_W-SQ_ROOT_W-2){1'b0}}, root_in, 2'b01};
            assign take = cur >= sub;

            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_val_reg[k][j]  <= {val_in[SQ_IN_W-3:0], 2'b00};
                    sq_rem_reg[k][j]  <= take ? (cur - sub) : cur;
                    sq_root_reg[k][j] <= {root_in[SQ_ROOT_W-2:0], take};
                end
            end
        end
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : gen_sq_side
        if (j == 0) begin : gen_first
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_side_reg[j] <= s5_side_reg;
                end
            end
        end else begin : gen_next
            always_ff @(posedge aclk) begin
                if (adv) begin
                    sq_side_reg[j] <= sq_side_reg[j-1];
                end
            end
        end
    end

    // Four angle pipelines: yaw, elevation of the reach, and the two arccosines.
    side_t               sq_out;
    logic signed [CW-1:0] cy_a, cy_b, cr_a, cr_b, cl_a, cl_b, cb_a, cb_b;
    logic signed [AW-1:0] ang_yaw, ang_reach, ang_acl, ang_acb;

    assign sq_out = sq_side_reg[SQ_STEPS-1];
    assign cy_a = {{(CW-15){sq_out.z[14]}}, sq_out.z};
    assign cy_b = {{(CW-15){sq_out.x[14]}}, sq_out.x};
    assign cr_a = {{(CW-25){sq_out.y[14]}}, sq_out.y, 10'd0};
    assign cr_b = {1'b0, sq_root_reg[0][SQ_STEPS-1]};
    assign cl_a = {1'b0, sq_root_reg[1][SQ_STEPS-1]};
    assign cl_b = sq_out.num_l;
    assign cb_a = {1'b0, sq_root_reg[2][SQ_STEPS-1]};
    assign cb_b = sq_out.num_b;

    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .aclk(aclk), .en(adv), .a_in(cy_a), .b_in(cy_b), .ang_out(ang_yaw));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_reach (
        .aclk(aclk), .en(adv), .a_in(cr_a), .b_in(cr_b), .ang_out(ang_reach));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_acl (
        .aclk(aclk), .en(adv), .a_in(cl_a), .b_in(cl_b), .ang_out(ang_acl));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_acb (
        .aclk(aclk), .en(adv), .a_in(cb_a), .b_in(cb_b), .ang_out(ang_acb));

    logic flag_dly_reg [CORDIC_STAGES+1];

    for (genvar i = 0; i <= CORDIC_STAGES; i++) begin : gen_flag_dly
        if (i == 0) begin : gen_first
            always_ff @(posedge aclk) begin
                if (adv) begin
                    flag_dly_reg[i] <= sq_out.flag;
                end
            end
        end else begin : gen_next
            always_ff @(posedge aclk) begin
                if (adv) begin
                    flag_dly_reg[i] <= flag_dly_reg[i-1];
                end
            end
        end
    end

    // Pulse scaling: yaw and lift are offset by a quarter turn, bend is 3pi/2 less
    // its angle; then scaled by 2000/pi, truncated toward zero, plus the servo center.
    logic signed [SUM_W-1:0] yaw_e, reach_e, acl_e, acb_e;
    logic signed [SUM_W-1:0] q1_sum_reg [3];
    logic                    q1_flag_reg;
    logic [PROD_W-1:0]       q2_prod_reg [3];
    logic [T_W-1:0]          q2_t_reg    [3];
    logic                    q2_neg_reg  [3];
    logic                    q2_flag_reg;
    logic [Q_W-1:0]          q3_qe_reg   [3];
    logic [REM_W-1:0]        q3_rem_reg  [3];
    logic                    q3_neg_reg  [3];
    logic                    q3_flag_reg;
    logic [11:0]             pulse_reg   [3];
    logic                    flag_out_reg;
    logic [11:0]             center      [3];

    assign yaw_e   = {{(SUM_W-AW){ang_yaw[AW-1]}}, ang_yaw};
    assign reach_e = {{(SUM_W-AW){ang_reach[AW-1]}}, ang_reach};
    assign acl_e   = {{(SUM_W-AW){ang_acl[AW-1]}}, ang_acl};
    assign acb_e   = {{(SUM_W-AW){ang_acb[AW-1]}}, ang_acb};

    assign center[0] = yaw_c_reg;
    assign center[1] = lift_c_reg;
    assign center[2] = bend_c_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_sum_reg[0] <= yaw_e + PH_S;
            q1_sum_reg[1] <= reach_e + acl_e + PH_S;
            q1_sum_reg[2] <= PI_PH_S - acb_e;
            q1_flag_reg   <= flag_dly_reg[CORDIC_STAGES];
            q2_flag_reg   <= q1_flag_reg;
            q3_flag_reg   <= q2_flag_reg;
            flag_out_reg  <= q3_flag_reg;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : gen_pulse
        logic signed [SUM_W-1:0]    neg_sum;
        logic [T_W-1:0]             t_abs;
        logic [Q_W-1:0]             qe;
        logic [Q_W+PI_W-1:0]        qp;
        logic [T_W+10:0]            t_scaled;
        logic [T_W+12:0]            rem_full;
        logic [Q_W-1:0]             q_fix;
        logic signed [V_W-1:0]      q_signed, v;

        assign neg_sum  = -q1_sum_reg[k];
        assign t_abs    = q1_sum_reg[k][SUM_W-1] ? neg_sum[T_W-1:0] : q1_sum_reg[k][T_W-1:0];
        assign qe       = q2_prod_reg[k][PROD_W-1:RECIP_SHIFT];
        assign qp       = qe * PI_U;
        assign t_scaled = q2_t_reg[k] * PULSE_SPAN;
        assign rem_full = {2'b00, t_scaled} - {1'b0, qp};
        // The reciprocal estimate is low by at most one.
        assign q_fix    = q3_qe_reg[k] + Q_W'(q3_rem_reg[k] >= {1'b0, PI_U});
        assign q_signed = q3_neg_reg[k] ? -$signed({2'b00, q_fix}) : $signed({2'b00, q_fix});
        assign v        = q_signed + $signed({5'd0, center[k]}) - PULSE_OFS;

        always_ff @(posedge aclk) begin
            if (adv) begin
                q2_prod_reg[k] <= t_abs * RECIP_K[K_W-1:0];
                q2_t_reg[k]    <= t_abs;
                q2_neg_reg[k]  <= q1_sum_reg[k][SUM_W-1];
                q3_qe_reg[k]   <= qe;
                q3_rem_reg[k]  <= rem_full[REM_W-1:0];
                q3_neg_reg[k]  <= q2_neg_reg[k];
                if (v[V_W-1]) begin
                    pulse_reg[k] <= '0;
                end else if (v > PULSE_MAX) begin
                    pulse_reg[k] <= 12'hFFF;
                end else begin
                    pulse_reg[k] <= v[11:0];
                end
            end
        end
    end

    assign m_yaw_pulse   = pulse_reg[0];
    assign m_lift_pulse  = pulse_reg[1];
    assign m_bend_pulse  = pulse_reg[2];
    assign m_unreachable = flag_out_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("pipeline not empty after reset");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("valid chain moved during a stall");

    a_item_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_bubble_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !vld_reg[LAT-2] |=> !m_valid)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire
